/* rtl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   // Widths fixed by the item and register layout.
   localparam int unsigned ModW = 31;
   localparam int unsigned OprW = 32;
   localparam int unsigned ExpW = 63;
   localparam int unsigned CntW = 5;

   // Modulus after reset.
   localparam logic [ModW-1:0] RESET_MODULUS = 31'd1000000007;

   // Operation modes of an input item.
   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_POW = 3'd4;

   // Operations of the shared iterative unit.
   localparam logic OP_DIV = 1'b0;
   localparam logic OP_MUL = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } mau_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mau_stat_type;

endpackage

/* rtl/mau_iter.sv */
// ----------------------------------------------------------------------------
// Shared iterative unit
// Restoring division (quotient and remainder) or shift-and-add modular
// multiply, one bit of x per cycle over its 32 bits.
// ----------------------------------------------------------------------------
module mau_iter
   import mau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mau_cmd_type        cmd,
   input  logic [OprW-1:0]    x,
   input  logic [ModW-1:0]    y,
   input  logic [ModW-1:0]    m,
   output mau_stat_type       stat,
   output logic [OprW-1:0]    quo,
   output logic [ModW-1:0]    rem
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              op_ff, op_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [OprW-1:0]   x_ff, x_in;
   logic [OprW-1:0]   acc_ff, acc_in;

   logic              bit_x;
   logic [OprW-1:0]   dt, dsub;
   logic              dge;
   logic [OprW-1:0]   md, md1, md2, md3;

   assign bit_x = x_ff[OprW-1];

   // Division step: shift in the next numerator bit and try a subtraction.
   assign dt   = {acc_ff[OprW-2:0], bit_x};
   assign dge  = dt >= {1'b0, y};
   assign dsub = dt - {1'b0, y};

   // Multiply step: double modulo m, then add y modulo m when the bit is set.
   assign md  = {acc_ff[OprW-2:0], 1'b0};
   assign md1 = (md >= {1'b0, m}) ? md - {1'b0, m} : md;
   assign md2 = md1 + (bit_x ? {1'b0, y} : {OprW{1'b0}});
   assign md3 = (md2 >= {1'b0, m}) ? md2 - {1'b0, m} : md2;

   // Sequencing of the 32 steps.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         x_in    = x;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            acc_in = dge ? dsub : dt;
            x_in   = {x_ff[OprW-2:0], dge};
         end else begin
            acc_in = md3;
            x_in   = {x_ff[OprW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {CntW{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo       = x_ff;
   assign rem       = acc_ff[ModW-1:0];

endmodule

/* rtl/modular_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, divide and power modulo a configurable modulus.
//
//   Channel  Direction  Handshake            Beat
//   req_     in         req_valid/req_stall  mode, operand_a, operand_b, exponent
//   rsp_     out        rsp_valid/rsp_stall  residue
//   csr_     in         csr_valid/csr_ready  modulus (31 bits)
//
// Every pass of the shared unit is a start, 32 steps and a done. Add and
// subtract take two passes, multiply three, divide 3 + 2 per Euclid round
// plus one check state a round, power 2 + 1 or 2 per exponent bit plus one
// check state a bit. Unused modes and a modulus below two answer at once.
// One item is worked on at a time; req_stall is high from acceptance until
// the result beat is taken. Reset restores the modulus.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit
   import mau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [OprW-1:0]    req_operand_a,
   input  logic [OprW-1:0]    req_operand_b,
   input  logic [ExpW-1:0]    req_exponent,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ModW-1:0]    rsp_residue,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ModW-1:0]    csr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_REDA  = 4'd1;
   localparam logic [3:0] ST_REDB  = 4'd2;
   localparam logic [3:0] ST_MULT  = 4'd3;
   localparam logic [3:0] ST_ECHK  = 4'd4;
   localparam logic [3:0] ST_EDIV  = 4'd5;
   localparam logic [3:0] ST_EMUL  = 4'd6;
   localparam logic [3:0] ST_EFIN  = 4'd7;
   localparam logic [3:0] ST_PCHK  = 4'd8;
   localparam logic [3:0] ST_PACC  = 4'd9;
   localparam logic [3:0] ST_PSQR  = 4'd10;
   localparam logic [3:0] ST_RESP  = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [ModW-1:0]   mod_ff, mod_in;
   logic [2:0]        mode_ff, mode_in;
   logic [OprW-1:0]   opa_ff, opa_in;
   logic [OprW-1:0]   opb_ff, opb_in;
   logic [ExpW-1:0]   exp_ff, exp_in;
   logic [ModW-1:0]   a_ff, a_in;
   logic [ModW-1:0]   r_ff, r_in;
   logic [ModW-1:0]   rn_ff, rn_in;
   logic [ModW-1:0]   s_ff, s_in;
   logic [ModW-1:0]   sn_ff, sn_in;
   logic [OprW-1:0]   q_ff, q_in;
   logic [ModW-1:0]   t_ff, t_in;
   logic [ModW-1:0]   res_ff, res_in;

   mau_cmd_type       cmd;
   mau_stat_type      stat;
   logic [OprW-1:0]   u_x;
   logic [ModW-1:0]   u_y;
   logic [OprW-1:0]   u_quo;
   logic [ModW-1:0]   u_rem;
   logic              in_op;

   logic [OprW-1:0]   add_s, sub_s, es_s;

   mau_iter u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .x     (u_x),
      .y     (u_y),
      .m     (mod_ff),
      .stat  (stat),
      .quo   (u_quo),
      .rem   (u_rem)
   );

   // Configuration register.
   assign csr_ready = 1'b1;
   always_comb begin
      mod_in = mod_ff;
      if (csr_valid && csr_ready) begin
         mod_in = csr_data;
      end
   end

   // Operand selection for the shared unit.
   assign in_op = (state_ff == ST_REDA) || (state_ff == ST_REDB) ||
                  (state_ff == ST_MULT) || (state_ff == ST_EDIV) ||
                  (state_ff == ST_EMUL) || (state_ff == ST_EFIN) ||
                  (state_ff == ST_PACC) || (state_ff == ST_PSQR);
   always_comb begin
      cmd.start = in_op && !stat.busy && !stat.done;
      cmd.op    = OP_MUL;
      u_x       = '0;
      u_y       = '0;
      case (state_ff)
         ST_REDA: begin
            cmd.op = OP_DIV;
            u_x    = opa_ff;
            u_y    = mod_ff;
         end
         ST_REDB: begin
            cmd.op = OP_DIV;
            u_x    = opb_ff;
            u_y    = mod_ff;
         end
         ST_MULT: begin
            u_x = {1'b0, a_ff};
            u_y = rn_ff;
         end
         ST_EDIV: begin
            cmd.op = OP_DIV;
            u_x    = {1'b0, r_ff};
            u_y    = rn_ff;
         end
         ST_EMUL: begin
            u_x = q_ff;
            u_y = sn_ff;
         end
         ST_EFIN: begin
            u_x = {1'b0, a_ff};
            u_y = s_ff;
         end
         ST_PACC: begin
            u_x = {1'b0, s_ff};
            u_y = a_ff;
         end
         ST_PSQR: begin
            u_x = {1'b0, a_ff};
            u_y = a_ff;
         end
         default: begin
            cmd.op = OP_MUL;
         end
      endcase
   end

   // Short arithmetic done beside the shared unit.
   assign add_s = {1'b0, a_ff} + {1'b0, u_rem};
   assign sub_s = (a_ff >= u_rem) ? {1'b0, a_ff} - {1'b0, u_rem}
                                  : {1'b0, a_ff} + {1'b0, mod_ff} - {1'b0, u_rem};
   assign es_s  = (s_ff >= u_rem) ? {1'b0, s_ff} - {1'b0, u_rem}
                                  : {1'b0, s_ff} + {1'b0, mod_ff} - {1'b0, u_rem};

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      exp_in   = exp_ff;
      a_in     = a_ff;
      r_in     = r_ff;
      rn_in    = rn_ff;
      s_in     = s_ff;
      sn_in    = sn_ff;
      q_in     = q_ff;
      t_in     = t_ff;
      res_in   = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               opa_in  = req_operand_a;
               opb_in  = req_operand_b;
               exp_in  = req_exponent;
               res_in  = '0;
               if ((mod_ff < 31'd2) || (req_mode > MODE_POW)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_REDA;
               end
            end
         end
         ST_REDA: begin
            if (stat.done) begin
               a_in     = u_rem;
               state_in = ST_REDB;
            end
         end
         ST_REDB: begin
            if (stat.done) begin
               case (mode_ff)
                  MODE_ADD: begin
                     res_in   = (add_s >= {1'b0, mod_ff}) ?
                                ModW'(add_s - {1'b0, mod_ff}) : ModW'(add_s);
                     state_in = ST_RESP;
                  end
                  MODE_SUB: begin
                     res_in   = ModW'(sub_s);
                     state_in = ST_RESP;
                  end
                  MODE_MUL: begin
                     rn_in    = u_rem;
                     state_in = ST_MULT;
                  end
                  MODE_DIV: begin
                     r_in     = mod_ff;
                     rn_in    = u_rem;
                     s_in     = '0;
                     sn_in    = ModW'(1);
                     state_in = ST_ECHK;
                  end
                  default: begin
                     s_in     = ModW'(1);
                     state_in = ST_PCHK;
                  end
               endcase
            end
         end
         ST_MULT: begin
            if (stat.done) begin
               res_in   = u_rem;
               state_in = ST_RESP;
            end
         end
         // Extended Euclid with the coefficients kept as residues.
         ST_ECHK: begin
            state_in = (rn_ff == '0) ? ST_EFIN : ST_EDIV;
         end
         ST_EDIV: begin
            if (stat.done) begin
               q_in     = u_quo;
               t_in     = u_rem;
               state_in = ST_EMUL;
            end
         end
         ST_EMUL: begin
            if (stat.done) begin
               r_in     = rn_ff;
               rn_in    = t_ff;
               s_in     = sn_ff;
               sn_in    = ModW'(es_s);
               state_in = ST_ECHK;
            end
         end
         ST_EFIN: begin
            if (stat.done) begin
               res_in   = u_rem;
               state_in = ST_RESP;
            end
         end
         // Square-and-multiply: s holds the accumulator, a the base.
         ST_PCHK: begin
            if (exp_ff == '0) begin
               res_in   = s_ff;
               state_in = ST_RESP;
            end else if (exp_ff[0]) begin
               state_in = ST_PACC;
            end else begin
               state_in = ST_PSQR;
            end
         end
         ST_PACC: begin
            if (stat.done) begin
               s_in     = u_rem;
               state_in = ST_PSQR;
            end
         end
         ST_PSQR: begin
            if (stat.done) begin
               a_in     = u_rem;
               exp_in   = exp_ff >> 1;
               state_in = ST_PCHK;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff   <= RESET_MODULUS;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
      end
      mode_ff <= mode_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      exp_ff  <= exp_in;
      a_ff    <= a_in;
      r_ff    <= r_in;
      rn_ff   <= rn_in;
      s_ff    <= s_in;
      sn_ff   <= sn_in;
      q_ff    <= q_in;
      t_ff    <= t_in;
      res_ff  <= res_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign rsp_residue = res_ff;

   // A result beat lies below the modulus when the modulus is at least two.
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (mod_ff >= 31'd2)) |-> (rsp_residue < mod_ff))
      else $error("residue not below modulus");

   // No result beat is offered while a new item can be taken.
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("result offered while idle");

   // The shared unit finishes only in a state that waits for it.
   a_done_in_op: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> in_op)
      else $error("shared unit finished outside an operation state");

   // A result beat held under stall keeps its value.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_residue)))
      else $error("stalled result changed");

endmodule
